// File: hdl/lcd_dot_timing_and_status_top_assert.svh
// assertion macros for the dot timing block checker
// depends on nothing; included by the checker file only
`ifndef LCD_DOT_TIMING_AND_STATUS_TOP_ASSERT_SVH
`define LCD_DOT_TIMING_AND_STATUS_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define LCDTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdts check failed");

// next-cycle implication under synchronous reset
`define LCDTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdts check failed");

`endif

// File: hdl/lcdts_pkg.sv
// shared types and constants for the dot timing and status block
// no dependencies
package lcdts_pkg;

   localparam int DOT_W        = 9;
   localparam int LINE_W       = 8;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 8;

   localparam int CLOCKS_PER_DOT_DEF  = 4;
   localparam int DOTS_PER_LINE_DEF   = 308;
   localparam int LINES_PER_FRAME_DEF = 228;
   localparam int VISIBLE_DOTS_DEF    = 240;
   localparam int VISIBLE_LINES_DEF   = 160;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_COMPARE   = 8'd0,
      REG_VBLANK_IRQ_EN  = 8'd1,
      REG_HBLANK_IRQ_EN  = 8'd2,
      REG_LMATCH_IRQ_EN  = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_compare;
      logic              vblank_irq_enable;
      logic              hblank_irq_enable;
      logic              line_match_irq_enable;
   } cfg_type;

   typedef struct packed {
      logic              dot_step;
      logic [DOT_W-1:0]  dot_position;
      logic [LINE_W-1:0] line_position;
      logic              vblank_flag;
      logic              hblank_flag;
      logic              visible_dot;
      logic              vblank_request;
      logic              hblank_request;
      logic              line_match_request;
   } result_type;

endpackage

// File: hdl/lcdts_csr.sv
// configuration registers of the dot timing block
// depends on lcdts_pkg
module lcdts_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [lcdts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcdts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lcdts_pkg::cfg_type                   cfg
);

   lcdts_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lcdts_pkg::REG_LINE_COMPARE:
               cfg_in.line_compare = csr_wdata[lcdts_pkg::LINE_W-1:0];
            lcdts_pkg::REG_VBLANK_IRQ_EN: cfg_in.vblank_irq_enable = csr_wdata[0];
            lcdts_pkg::REG_HBLANK_IRQ_EN: cfg_in.hblank_irq_enable = csr_wdata[0];
            lcdts_pkg::REG_LMATCH_IRQ_EN: cfg_in.line_match_irq_enable = csr_wdata[0];
            default: ; // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/lcdts_timing.sv
// prescaler, dot and line counters, held flags and request decode
// depends on lcdts_pkg
module lcdts_timing #(
   parameter int CLOCKS_PER_DOT  = lcdts_pkg::CLOCKS_PER_DOT_DEF,
   parameter int DOTS_PER_LINE   = lcdts_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = lcdts_pkg::LINES_PER_FRAME_DEF,
   parameter int VISIBLE_DOTS    = lcdts_pkg::VISIBLE_DOTS_DEF,
   parameter int VISIBLE_LINES   = lcdts_pkg::VISIBLE_LINES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   tick,
   input  lcdts_pkg::cfg_type     cfg,
   output lcdts_pkg::result_type  result
);

   localparam int PHASE_W = (CLOCKS_PER_DOT > 1) ? $clog2(CLOCKS_PER_DOT) : 1;
   localparam int DOT_W   = lcdts_pkg::DOT_W;
   localparam int LINE_W  = lcdts_pkg::LINE_W;

   localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(CLOCKS_PER_DOT - 1);
   localparam logic [DOT_W:0]     DOT_WRAP    = (DOT_W + 1)'(DOTS_PER_LINE);
   localparam logic [LINE_W:0]    LINE_WRAP   = (LINE_W + 1)'(LINES_PER_FRAME);
   localparam logic [LINE_W-1:0]  LINE_LAST   = LINE_W'(LINES_PER_FRAME - 1);
   localparam logic [DOT_W-1:0]   VIS_DOTS    = DOT_W'(VISIBLE_DOTS);
   localparam logic [LINE_W-1:0]  VIS_LINES   = LINE_W'(VISIBLE_LINES);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [DOT_W-1:0]   dot_ff, dot_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic               vblank_ff, vblank_in;
   logic               hblank_ff, hblank_in;

   logic               step;
   logic               dot_zero;
   logic [DOT_W:0]     dot_sum;
   logic [LINE_W:0]    line_sum;

   always_comb begin
      step      = tick && (phase_ff == '0);
      dot_zero  = (dot_ff == '0);
      dot_sum   = {1'b0, dot_ff} + 1'b1;
      line_sum  = {1'b0, line_ff} + 1'b1;

      phase_in  = phase_ff;
      dot_in    = dot_ff;
      line_in   = line_ff;
      vblank_in = vblank_ff;
      hblank_in = hblank_ff;

      if (tick) begin
         phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
      end
      if (step) begin
         vblank_in = (line_ff >= VIS_LINES) && (line_ff != LINE_LAST);
         hblank_in = (dot_ff >= VIS_DOTS);
         if (dot_sum >= DOT_WRAP) begin
            dot_in  = '0;
            line_in = (line_sum >= LINE_WRAP) ? '0 : line_sum[LINE_W-1:0];
         end else begin
            dot_in  = dot_sum[DOT_W-1:0];
         end
      end

      result.dot_step           = step;
      result.dot_position       = dot_ff;
      result.line_position      = line_ff;
      result.vblank_flag        = vblank_in;
      result.hblank_flag        = hblank_in;
      result.visible_dot        = step && (dot_ff < VIS_DOTS) && (line_ff < VIS_LINES);
      result.vblank_request     = step && dot_zero && (line_ff == VIS_LINES)
                                  && cfg.vblank_irq_enable;
      result.hblank_request     = step && (dot_ff == VIS_DOTS) && cfg.hblank_irq_enable;
      result.line_match_request = step && dot_zero && (line_ff == cfg.line_compare)
                                  && cfg.line_match_irq_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         dot_ff    <= '0;
         line_ff   <= '0;
         vblank_ff <= 1'b0;
         hblank_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         dot_ff    <= dot_in;
         line_ff   <= line_in;
         vblank_ff <= vblank_in;
         hblank_ff <= hblank_in;
      end
   end

endmodule

// File: hdl/lcdts_rsp_reg.sv
// result register between timing logic and the response channel
// depends on lcdts_pkg
module lcdts_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lcdts_pkg::result_type  result,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   busy,
   output lcdts_pkg::result_type  rsp_data
);

   logic                  valid_ff, valid_in;
   lcdts_pkg::result_type data_ff, data_in;

   always_comb begin
      busy     = valid_ff && rsp_stall;
      valid_in = load || busy;
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hdl/lcd_dot_timing_and_status_top.sv
// top level of the lcd dot timing and status block
// depends on lcdts_pkg, lcdts_csr, lcdts_timing, lcdts_rsp_reg
//
// usage
//   req channel: one beat per machine clock, req_tick = 1 lets the clock count,
//     req_tick = 0 is a beat that holds all timing state
//   rsp channel: exactly one beat per req beat, in order, carrying the dot and
//     line position, held vblank/hblank flags, visible-dot and irq pulses
//   csr channel: csr_index selects line compare (0), vblank irq enable (1),
//     hblank irq enable (2), line match irq enable (3); other indexes are
//     dropped; csr_ready is always high so a write is never held off
// throughput
//   one beat per cycle sustained while rsp_stall is low; the counter update
//   and flag decode fit between the req edge and the result register, so the
//   only limit is the single result register
// stall
//   req_stall is high only while a result waits in the result register and
//   rsp_stall holds it; a beat taken in the same cycle the result leaves is
//   accepted, so back-to-back flow continues with no bubble
// reset
//   synchronous active high reset clears prescaler, counters, flags, irq
//   enables, line compare and the result valid; no clearing pass is needed
module lcd_dot_timing_and_status_top #(
   parameter int CLOCKS_PER_DOT  = lcdts_pkg::CLOCKS_PER_DOT_DEF,
   parameter int DOTS_PER_LINE   = lcdts_pkg::DOTS_PER_LINE_DEF,
   parameter int LINES_PER_FRAME = lcdts_pkg::LINES_PER_FRAME_DEF,
   parameter int VISIBLE_DOTS    = lcdts_pkg::VISIBLE_DOTS_DEF,
   parameter int VISIBLE_LINES   = lcdts_pkg::VISIBLE_LINES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_tick,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_dot_step,
   output logic [lcdts_pkg::DOT_W-1:0]          rsp_dot_position,
   output logic [lcdts_pkg::LINE_W-1:0]         rsp_line_position,
   output logic                                 rsp_vblank_flag,
   output logic                                 rsp_hblank_flag,
   output logic                                 rsp_visible_dot,
   output logic                                 rsp_vblank_request,
   output logic                                 rsp_hblank_request,
   output logic                                 rsp_line_match_request,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcdts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcdts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lcdts_pkg::cfg_type    cfg;
   lcdts_pkg::result_type result;
   lcdts_pkg::result_type rsp_data;
   logic                  busy;
   logic                  req_take;

   // register writes never wait
   assign csr_ready = 1'b1;

   // a beat is taken whenever the result register is free or draining
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;

   lcdts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // timing state only moves on a taken beat
   lcdts_timing #(
      .CLOCKS_PER_DOT  (CLOCKS_PER_DOT),
      .DOTS_PER_LINE   (DOTS_PER_LINE),
      .LINES_PER_FRAME (LINES_PER_FRAME),
      .VISIBLE_DOTS    (VISIBLE_DOTS),
      .VISIBLE_LINES   (VISIBLE_LINES)
   ) u_timing (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .tick    (req_tick),
      .cfg     (cfg),
      .result  (result)
   );

   lcdts_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .busy      (busy),
      .rsp_data  (rsp_data)
   );

   // unpack the result beat onto its ports
   assign rsp_dot_step           = rsp_data.dot_step;
   assign rsp_dot_position       = rsp_data.dot_position;
   assign rsp_line_position      = rsp_data.line_position;
   assign rsp_vblank_flag        = rsp_data.vblank_flag;
   assign rsp_hblank_flag        = rsp_data.hblank_flag;
   assign rsp_visible_dot        = rsp_data.visible_dot;
   assign rsp_vblank_request     = rsp_data.vblank_request;
   assign rsp_hblank_request     = rsp_data.hblank_request;
   assign rsp_line_match_request = rsp_data.line_match_request;

endmodule

// File: hdl/lcdts_checker.sv
// port-level checks for the dot timing block, bound to the top level
// depends on lcdts_pkg and lcd_dot_timing_and_status_top_assert.svh
`include "lcd_dot_timing_and_status_top_assert.svh"

module lcdts_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_tick,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_dot_step,
   input  logic [lcdts_pkg::DOT_W-1:0]    rsp_dot_position,
   input  logic                           rsp_hblank_flag,
   input  logic                           rsp_visible_dot,
   input  logic                           rsp_vblank_request,
   input  logic                           rsp_hblank_request,
   input  logic                           rsp_line_match_request
);

   // held result stays put
   `LCDTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dot_position))
   // a held beat of tick zero answers next cycle with no dot step
   `LCDTS_ASSERT_NEXT(a_idle_tick, clock, reset, req_valid && !req_stall && !req_tick, rsp_valid && !rsp_dot_step)
   // pulses and visibility only on dot steps
   `LCDTS_ASSERT_SAME(a_pulse_on_step, clock, reset, rsp_valid && !rsp_dot_step, !rsp_visible_dot && !rsp_vblank_request && !rsp_hblank_request && !rsp_line_match_request)
   // hblank request comes with the hblank flag set
   `LCDTS_ASSERT_SAME(a_hreq_flag, clock, reset, rsp_valid && rsp_hblank_request, rsp_hblank_flag && !rsp_visible_dot)

endmodule

bind lcd_dot_timing_and_status_top lcdts_checker u_lcdts_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .req_tick               (req_tick),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_dot_step           (rsp_dot_step),
   .rsp_dot_position       (rsp_dot_position),
   .rsp_hblank_flag        (rsp_hblank_flag),
   .rsp_visible_dot        (rsp_visible_dot),
   .rsp_vblank_request     (rsp_vblank_request),
   .rsp_hblank_request     (rsp_hblank_request),
   .rsp_line_match_request (rsp_line_match_request)
);

// File: bench/lcd_dot_timing_and_status_top_tb.sv
// self-checking bench for lcd_dot_timing_and_status_top: directed rows, then
// random hold/tick traffic through hblank and across the first line wrap
// depends on lcdts_pkg and the rtl of the block, nothing else
`timescale 1ns / 1ps

module lcd_dot_timing_and_status_top_tb;

   localparam int CPD         = lcdts_pkg::CLOCKS_PER_DOT_DEF;
   localparam int DOTS        = lcdts_pkg::DOTS_PER_LINE_DEF;
   localparam int LINES       = lcdts_pkg::LINES_PER_FRAME_DEF;
   localparam int VIS_DOTS    = lcdts_pkg::VISIBLE_DOTS_DEF;
   localparam int VIS_LINES   = lcdts_pkg::VISIBLE_LINES_DEF;
   localparam int DOT_W       = lcdts_pkg::DOT_W;
   localparam int LINE_W      = lcdts_pkg::LINE_W;
   localparam int CSR_INDEX_W = lcdts_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = lcdts_pkg::CSR_DATA_W;
   // cycles with no beat on any channel before the run is called dead
   localparam int STALL_LIMIT = 2000;
   localparam int DIR_ROWS    = 16;

   // one directed stimulus row; want is only used when pinned is set
   typedef struct packed {
      logic                  tick;
      logic                  pinned;
      lcdts_pkg::result_type want;
   } dir_row_type;

   logic clock;
   logic reset       = 1'b1;
   logic req_valid   = 1'b0;
   logic req_stall;
   logic req_tick    = 1'b0;
   logic rsp_valid;
   logic rsp_stall   = 1'b0;
   logic rsp_dot_step;
   logic [DOT_W-1:0]  rsp_dot_position;
   logic [LINE_W-1:0] rsp_line_position;
   logic rsp_vblank_flag;
   logic rsp_hblank_flag;
   logic rsp_visible_dot;
   logic rsp_vblank_request;
   logic rsp_hblank_request;
   logic rsp_line_match_request;
   logic csr_valid   = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // typed-in expectation travelling with the req beat it belongs to
   logic                  beat_pinned = 1'b0;
   lcdts_pkg::result_type beat_want   = '0;

   // timing model: prescaler, counters, held flags and register shadow
   logic [1:0]         phase_now  = '0;
   logic [DOT_W-1:0]   dot_now    = '0;
   logic [LINE_W-1:0]  line_now   = '0;
   logic               vblank_now = 1'b0;
   logic               hblank_now = 1'b0;
   lcdts_pkg::cfg_type cfg_now    = '0;

   lcdts_pkg::result_type expected_timing [$];
   int  mismatches  = 0;
   int  beats_seen  = 0;
   int  idle_cycles = 0;

   // stimulus-side bookkeeping, only touched by the stimulus process
   longint ticks_sent = 0;
   int     calm_beats = 0;

   lcd_dot_timing_and_status_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_tick               (req_tick),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_dot_step           (rsp_dot_step),
      .rsp_dot_position       (rsp_dot_position),
      .rsp_line_position      (rsp_line_position),
      .rsp_vblank_flag        (rsp_vblank_flag),
      .rsp_hblank_flag        (rsp_hblank_flag),
      .rsp_visible_dot        (rsp_visible_dot),
      .rsp_vblank_request     (rsp_vblank_request),
      .rsp_hblank_request     (rsp_hblank_request),
      .rsp_line_match_request (rsp_line_match_request),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // advance the timing model by one machine clock and return its result beat
   function automatic lcdts_pkg::result_type advance_dot_timing(input logic tick);
      lcdts_pkg::result_type r;
      r = '0;
      // position is reported before the counters move
      r.dot_position  = dot_now;
      r.line_position = line_now;
      if (tick) begin
         if (phase_now == 0) begin
            r.dot_step = 1'b1;
            vblank_now = (line_now >= VIS_LINES) && (line_now != LINES - 1);
            hblank_now = (dot_now >= VIS_DOTS);
            r.visible_dot        = (dot_now < VIS_DOTS) && (line_now < VIS_LINES);
            r.hblank_request     = (dot_now == VIS_DOTS) && cfg_now.hblank_irq_enable;
            r.vblank_request     = (line_now == VIS_LINES) && (dot_now == 0)
                                   && cfg_now.vblank_irq_enable;
            r.line_match_request = (line_now == cfg_now.line_compare) && (dot_now == 0)
                                   && cfg_now.line_match_irq_enable;
            if (dot_now == DOTS - 1) begin
               dot_now  = '0;
               line_now = (line_now == LINES - 1) ? '0 : line_now + 1'b1;
            end else begin
               dot_now = dot_now + 1'b1;
            end
         end
         phase_now = (phase_now == CPD - 1) ? '0 : phase_now + 1'b1;
      end
      // flags are held values, valid on every beat
      r.vblank_flag = vblank_now;
      r.hblank_flag = hblank_now;
      return r;
   endfunction

   // monitor: model update on req beats, register shadow on csr writes,
   // and in-order compare of every rsp beat against the oldest expectation
   always @(posedge clock) begin
      lcdts_pkg::result_type predicted;
      lcdts_pkg::result_type got;
      lcdts_pkg::result_type want;
      if (reset) begin
         phase_now  = '0;
         dot_now    = '0;
         line_now   = '0;
         vblank_now = 1'b0;
         hblank_now = 1'b0;
         cfg_now    = '0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = advance_dot_timing(req_tick);
            // directed rows with a typed-in answer override the model
            expected_timing.push_back(beat_pinned ? beat_want : predicted);
         end
         if (csr_valid && csr_ready) begin
            case (lcdts_pkg::reg_index_type'(csr_index))
               lcdts_pkg::REG_LINE_COMPARE:  cfg_now.line_compare          = csr_wdata;
               lcdts_pkg::REG_VBLANK_IRQ_EN: cfg_now.vblank_irq_enable     = csr_wdata[0];
               lcdts_pkg::REG_HBLANK_IRQ_EN: cfg_now.hblank_irq_enable     = csr_wdata[0];
               lcdts_pkg::REG_LMATCH_IRQ_EN: cfg_now.line_match_irq_enable = csr_wdata[0];
               default: ;   // writes to unknown indexes are dropped
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.dot_step           = rsp_dot_step;
            got.dot_position       = rsp_dot_position;
            got.line_position      = rsp_line_position;
            got.vblank_flag        = rsp_vblank_flag;
            got.hblank_flag        = rsp_hblank_flag;
            got.visible_dot        = rsp_visible_dot;
            got.vblank_request     = rsp_vblank_request;
            got.hblank_request     = rsp_hblank_request;
            got.line_match_request = rsp_line_match_request;
            if (expected_timing.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: rsp beat %0d with nothing expected, got %p", beats_seen, got);
            end else begin
               want = expected_timing.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("tb: rsp beat %0d mismatch\n  expected %p\n  actual   %p",
                              beats_seen, want, got);
               end
            end
            beats_seen++;
         end
      end
   end

   // watchdog on cycles in which no channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int pause_len();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(3, 1);
      return $urandom_range(30, 4);
   endfunction

   // receiver pacing: random stall bursts, with long stall-free stretches
   initial begin : rsp_pacing
      int n;
      forever begin
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(600, 100)) @(posedge clock);
         else
            repeat ($urandom_range(12, 1)) @(posedge clock);
         n = pause_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // sender gap before the next beat; calm stretches send back to back
   function automatic int next_gap();
      if (calm_beats > 0) begin
         calm_beats--;
         return 0;
      end
      if ($urandom_range(49) == 0) calm_beats = $urandom_range(600, 100);
      return pause_len();
   endfunction

   // line the block is on after the ticks sent so far
   function automatic int line_of_ticks();
      longint steps;
      steps = (ticks_sent + CPD - 1) / CPD;
      return int'((steps / DOTS) % LINES);
   endfunction

   // one req beat; valid stays high afterward so beats can follow back to back
   task automatic send_beat(input logic tick, input logic pinned,
                            input lcdts_pkg::result_type want, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_tick    <= tick;
      beat_pinned <= pinned;
      beat_want   <= want;
      do @(posedge clock); while (req_stall);
      if (tick) ticks_sent++;
   endtask

   // stop sending until every expected rsp beat has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_timing.size() != 0);
   endtask

   // csr beat; leaves csr_valid high, caller lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [7:0] compare, input logic [7:0] ven,
                            input logic [7:0] hen, input logic [7:0] len);
      drain_results();
      write_reg(lcdts_pkg::REG_LINE_COMPARE, compare);
      write_reg(lcdts_pkg::REG_VBLANK_IRQ_EN, ven);
      write_reg(lcdts_pkg::REG_HBLANK_IRQ_EN, hen);
      write_reg(lcdts_pkg::REG_LMATCH_IRQ_EN, len);
      csr_valid <= 1'b0;
   endtask

   // almost all ticking beats with the odd hold beat, until the target line starts
   task automatic run_until_line(input int target);
      while (line_of_ticks() != target)
         send_beat($urandom_range(49) != 0, 1'b0, '0, next_gap());
   endtask

   // rsp with the reset frame position: line 0, flags clear, no irq
   function automatic lcdts_pkg::result_type start_rsp(input logic step, input int dot,
                                                       input logic vis);
      lcdts_pkg::result_type r;
      r = '0;
      r.dot_step     = step;
      r.dot_position = DOT_W'(dot);
      r.visible_dot  = vis;
      return r;
   endfunction

   initial begin : stimulus
      dir_row_type dir_rows [0:DIR_ROWS-1];

      // hold beats and every prescaler phase right after reset;
      // irq enables are all off so no request can pulse
      dir_rows = '{
         '{1'b0, 1'b1, start_rsp(1'b0, 0, 1'b0)},   // hold at phase zero
         '{1'b1, 1'b1, start_rsp(1'b1, 0, 1'b1)},   // first dot step
         '{1'b0, 1'b1, start_rsp(1'b0, 1, 1'b0)},   // hold mid-dot
         '{1'b1, 1'b1, start_rsp(1'b0, 1, 1'b0)},
         '{1'b0, 1'b1, start_rsp(1'b0, 1, 1'b0)},
         '{1'b1, 1'b1, start_rsp(1'b0, 1, 1'b0)},
         '{1'b1, 1'b1, start_rsp(1'b0, 1, 1'b0)},   // prescaler wraps
         '{1'b1, 1'b1, start_rsp(1'b1, 1, 1'b1)},   // second dot step
         '{1'b0, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b0, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)},
         '{1'b1, 1'b0, lcdts_pkg::result_type'('0)}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows, sent with random gaps like the rest
      for (int i = 0; i < DIR_ROWS; i++)
         send_beat(dir_rows[i].tick, dir_rows[i].pinned, dir_rows[i].want, pause_len());

      // compare beyond the last line never matches; an enable write with
      // bit zero clear turns the irq off; unknown indexes must not land
      configure(8'd255, 8'hFE, 8'd1, 8'd1);
      @(posedge clock);
      write_reg(8'd4, 8'h55);
      write_reg(8'hFF, 8'hAA);
      csr_valid <= 1'b0;
      for (int i = 0; i < 60; i++)
         send_beat($urandom_range(9) < 7, 1'b0, '0, next_gap());

      // all irqs on, match on line 1; through the hblank request and the
      // first line wrap, then past dot 0 of line 1
      configure(8'd1, 8'd1, 8'd1, 8'd1);
      run_until_line(1);
      for (int i = 0; i < 30; i++)
         send_beat($urandom_range(9) < 7, 1'b0, '0, next_gap());

      // wait out the last results, then let the result register empty
      drain_results();
      repeat (10) @(posedge clock);

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
